// ----- hdl/lqh_pkg.sv -----
package lqh_pkg;

  localparam int KeyW    = 31;
  localparam int SizeW   = 11;
  localparam int SlotW   = 10;
  localparam int StatW   = 3;
  localparam int DivCntW = $clog2(KeyW);

  // operation codes
  localparam logic KindInsert = 1'b0;
  localparam logic KindQuery  = 1'b1;

  // result status codes
  localparam logic [StatW-1:0] StHome    = 3'd0;
  localparam logic [StatW-1:0] StProbed  = 3'd1;
  localparam logic [StatW-1:0] StFull    = 3'd2;
  localparam logic [StatW-1:0] StFound   = 3'd3;
  localparam logic [StatW-1:0] StMissing = 3'd4;

  localparam logic [SizeW-1:0] SizeReset = 11'd1024;

  typedef struct packed {
    logic            kind;
    logic [KeyW-1:0] key;
  } in_t;

  typedef struct packed {
    logic [StatW-1:0] status;
    logic [SlotW-1:0] slot_index;
    logic [SizeW-1:0] probe_count;
  } out_t;

endpackage

// ----- hdl/linear_quotient_hash_table_top.sv -----
// Linear quotient hash table: insert and probe-count query on one memory.
// Each item runs two divisions (key / size, quotient mod size) on one shared
// compare-subtract unit, then a memory read and a check per probe, then emit.
// A new item is taken only in idle, after the last result went to the output.
// Reset: table size returns to 1024 and a clearing pass over min(1024, TABLE_DEPTH)
// slots runs; each size write starts a pass over the size in use.
module linear_quotient_hash_table_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lqh_pkg::in_t                in_item_i,
  // result item channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lqh_pkg::out_t               out_item_o,
  // table size register write
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [lqh_pkg::SizeW-1:0]   cfg_data_i
);

  import lqh_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // One memory word: valid flag plus stored key.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
  } slot_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV1,   // key / size: remainder is the home slot
    S_DIV2,   // quotient mod size: the step
    S_READ,   // issue memory read at current slot
    S_CHECK,  // evaluate the slot read back
    S_EMIT    // hand result to the output register
  } state_e;

  state_e              state_q;
  logic [SizeW-1:0]    tsize_q;
  logic [SizeW-1:0]    clr_cnt_q;
  logic                kind_q;
  logic [KeyW-1:0]     key_q;
  logic [KeyW-1:0]     div_q;     // dividend in, quotient shifts in at the bottom
  logic [SizeW-1:0]    rem_q;
  logic [DivCntW-1:0]  cnt_q;
  logic [SizeW-1:0]    home_q;
  logic [SizeW-1:0]    step_q;
  logic [SizeW-1:0]    pos_q;
  logic [SizeW-1:0]    probes_q;
  out_t                res_q;
  out_t                out_q;
  logic                out_valid_q;
  slot_t               rd_q;

  slot_t               mem_q [TABLE_DEPTH];

  logic [SizeW-1:0]    used_n;
  logic [SizeW:0]      unit_x;
  logic [SizeW:0]      unit_diff;
  logic                unit_ge;
  logic [SizeW-1:0]    unit_y;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  slot_t               mem_wdata;
  logic                in_acc;
  logic                out_free;

  // Size in use: zero acts as one, anything past the memory depth is clamped.
  always_comb begin
    if (tsize_q == '0) begin
      used_n = SizeW'(1);
    end else if (32'(tsize_q) > 32'(TABLE_DEPTH)) begin
      used_n = SizeW'(TABLE_DEPTH);
    end else begin
      used_n = tsize_q;
    end
  end

  // Shared compare-subtract unit: reduces a value below 2*n into [0, n).
  // Divide steps feed {rem, next dividend bit}; the walk feeds pos + step.
  always_comb begin
    if (state_q == S_CHECK) begin
      unit_x = (SizeW+1)'(pos_q) + (SizeW+1)'(step_q);
    end else begin
      unit_x = {rem_q, div_q[KeyW-1]};
    end
    unit_diff = unit_x - {1'b0, used_n};
    unit_ge   = (unit_x >= {1'b0, used_n});
    unit_y    = unit_ge ? unit_diff[SizeW-1:0] : unit_x[SizeW-1:0];
  end

  assign cfg_ready_o = 1'b1;
  // config write takes priority over a new item on the same edge
  assign in_stall_o  = (state_q != S_IDLE) || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Memory write: clearing pass, or an insert landing on an empty slot.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = AW'(pos_q);
    mem_wdata = '{valid: 1'b1, key: key_q};
    if (state_q == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = AW'(clr_cnt_q);
      mem_wdata = '{valid: 1'b0, key: '0};
    end else if (state_q == S_CHECK && kind_q == KindInsert && !rd_q.valid) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    if (state_q == S_READ) begin
      rd_q <= mem_q[AW'(pos_q)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      tsize_q     <= SizeReset;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      if (cfg_valid_i) begin
        // new size: restart the clearing pass
        tsize_q   <= cfg_data_i;
        clr_cnt_q <= '0;
        state_q   <= S_CLEAR;
      end else begin
        unique case (state_q)
          S_CLEAR: begin
            clr_cnt_q <= clr_cnt_q + SizeW'(1);
            if (clr_cnt_q == used_n - SizeW'(1)) begin
              state_q <= S_IDLE;
            end
          end

          S_IDLE: begin
            if (in_acc) begin
              kind_q  <= in_item_i.kind;
              key_q   <= in_item_i.key;
              div_q   <= in_item_i.key;
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= S_DIV1;
            end
          end

          S_DIV1: begin
            div_q <= {div_q[KeyW-2:0], unit_ge};
            cnt_q <= cnt_q + DivCntW'(1);
            rem_q <= unit_y;
            if (cnt_q == DivCntW'(KeyW - 1)) begin
              home_q  <= unit_y;
              rem_q   <= '0;
              cnt_q   <= '0;
              state_q <= S_DIV2;
            end
          end

          S_DIV2: begin
            div_q <= {div_q[KeyW-2:0], unit_ge};
            cnt_q <= cnt_q + DivCntW'(1);
            rem_q <= unit_y;
            if (cnt_q == DivCntW'(KeyW - 1)) begin
              // zero step would never move off home
              step_q   <= (unit_y == '0) ? SizeW'(1) : unit_y;
              pos_q    <= home_q;
              probes_q <= SizeW'(1);
              state_q  <= S_READ;
            end
          end

          S_READ: begin
            state_q <= S_CHECK;
          end

          S_CHECK: begin
            state_q <= S_EMIT;
            if (kind_q == KindInsert && !rd_q.valid) begin
              res_q.status      <= (probes_q == SizeW'(1)) ? StHome : StProbed;
              res_q.slot_index  <= SlotW'(pos_q);
              res_q.probe_count <= probes_q;
            end else if (kind_q == KindQuery && !rd_q.valid) begin
              res_q.status      <= StMissing;
              res_q.slot_index  <= '0;
              res_q.probe_count <= probes_q;
            end else if (kind_q == KindQuery && rd_q.key == key_q) begin
              res_q.status      <= StFound;
              res_q.slot_index  <= SlotW'(pos_q);
              res_q.probe_count <= probes_q;
            end else if (probes_q == used_n) begin
              // walked the whole size without success
              res_q.status      <= (kind_q == KindInsert) ? StFull : StMissing;
              res_q.slot_index  <= '0;
              res_q.probe_count <= used_n;
            end else begin
              probes_q <= probes_q + SizeW'(1);
              pos_q    <= unit_y;
              state_q  <= S_READ;
            end
          end

          S_EMIT: begin
            if (out_free) begin
              out_q       <= res_q;
              out_valid_q <= 1'b1;
              state_q     <= S_IDLE;
            end
          end

          default: begin
            state_q <= S_IDLE;
          end
        endcase
      end
    end
  end

endmodule

// ----- sim/tb_linear_quotient_hash_table_top.sv -----
`timescale 1ns / 1ps

module tb_linear_quotient_hash_table_top;
  import lqh_pkg::*;

  localparam int unsigned TableDepth   = 1024;
  // idle cycles after the last result before a size write or a drain releases
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned TailCycles   = 200;
  // longest idle stretch either side draws
  localparam int unsigned MaxIdle      = 200;

  // what the driver pulls off its work list
  typedef enum logic [1:0] {
    CmdItem,
    CmdSize,
    CmdDrain
  } cmd_kind_e;

  typedef struct {
    cmd_kind_e        kind;
    in_t              item;
    logic [SizeW-1:0] size;
    int unsigned      gap;
  } cmd_t;

  // ---------------------------------------------------------------------------
  // clock, reset and block ports
  // ---------------------------------------------------------------------------
  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  in_t              in_item_i   = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  out_t             out_item_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [SizeW-1:0] cfg_data_i  = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  linear_quotient_hash_table_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // shadow table: its own copy of keys, occupancy and the size register
  // ---------------------------------------------------------------------------
  logic [KeyW-1:0]  mdl_key  [TableDepth];
  bit               mdl_used [TableDepth];
  logic [SizeW-1:0] mdl_size = SizeReset;

  // bookkeeping
  cmd_t             stim_q[$];
  out_t             due_results[$];
  logic [KeyW-1:0]  gen_keys[$];     // keys inserted so far in the phase being built
  int unsigned      gen_span  = TableDepth;
  bit               gen_calm  = 1'b0;
  longint unsigned  budget    = 0;
  longint unsigned  cycle_limit = 64'hFFFF_FFFF;
  longint unsigned  cyc_cnt   = 0;
  int unsigned      gap_cnt   = 0;
  int unsigned      settle_cnt = 0;
  int unsigned      hold_left = 0;
  int unsigned      n_issued  = 0;
  int unsigned      n_retired = 0;
  int unsigned      n_inserts = 0;
  int unsigned      n_queries = 0;
  int unsigned      n_size_writes = 0;
  int unsigned      status_hits[5];
  int               error_cnt = 0;

  // Size register as the walk sees it: zero acts as one, oversize clamps.
  function automatic int unsigned span_of(logic [SizeW-1:0] sz);
    if (sz == 0) return 1;
    if (sz > TableDepth) return TableDepth;
    return 32'(sz);
  endfunction

  // Walks the shadow table for one item and returns the result it should give.
  // Inserts land in the first free slot; queries stop at a free slot or a match.
  // A path that never reaches either is cut off after span probes.
  function automatic out_t walk_table(in_t it);
    int unsigned n;
    int unsigned pos;
    int unsigned stride;
    int unsigned probes;
    bit          done;
    out_t        res;
    n      = span_of(mdl_size);
    pos    = it.key % n;
    stride = (it.key / n) % n;
    if (stride == 0) stride = 1;   // a zero step would never leave home
    res    = '0;
    done   = 1'b0;
    probes = 1;
    while (!done && probes <= n) begin
      if (it.kind == KindInsert) begin
        if (!mdl_used[pos]) begin
          mdl_key[pos]    = it.key;
          mdl_used[pos]   = 1'b1;
          res.status      = (probes == 1) ? StHome : StProbed;
          res.slot_index  = pos[SlotW-1:0];
          res.probe_count = probes[SizeW-1:0];
          done            = 1'b1;
        end
      end else if (!mdl_used[pos]) begin
        // empty slot ends the search and counts as a probe
        res.status      = StMissing;
        res.probe_count = probes[SizeW-1:0];
        done            = 1'b1;
      end else if (mdl_key[pos] == it.key) begin
        res.status      = StFound;
        res.slot_index  = pos[SlotW-1:0];
        res.probe_count = probes[SizeW-1:0];
        done            = 1'b1;
      end
      if (!done) begin
        pos    = (pos + stride) % n;
        probes = probes + 1;
      end
    end
    if (!done) begin
      res.status      = (it.kind == KindInsert) ? StFull : StMissing;
      res.probe_count = n[SizeW-1:0];
    end
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long.
  function automatic int unsigned draw_idle();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 16);
    return $urandom_range(40, MaxIdle);
  endfunction

  // Keys: full-range random, small keys (quotient up to three spans) with random home, and keys whose
  // step is half or a quarter of the span so the path cycles over few slots.
  function automatic logic [KeyW-1:0] draw_key(int unsigned n);
    logic [31:0]     raw;
    longint unsigned q;
    longint unsigned h;
    longint unsigned s;
    longint unsigned hi;
    longint unsigned lim;
    int unsigned     r;
    r   = $urandom_range(0, 9);
    raw = $urandom();
    h   = $urandom_range(0, n - 1);
    if (r < 4) return raw[KeyW-1:0];
    if (r < 8) begin
      q = $urandom_range(0, 3 * n);
      return KeyW'(q * n + h);
    end
    s   = (r == 8) ? n / 2 : n / 4;
    lim = 64'd2147483647 / (longint'(n) * n);
    hi  = (lim > 1) ? $urandom_range(0, int'(lim - 2)) : 0;
    return KeyW'((hi * n + s) * n + h);
  endfunction

  task automatic push_item(input logic kind, input logic [KeyW-1:0] key);
    cmd_t c;
    c.kind      = CmdItem;
    c.item.kind = kind;
    c.item.key  = key;
    c.size      = '0;
    c.gap       = gen_calm ? 0 : draw_idle();
    stim_q = {stim_q, c};
    budget += 70 + 2 * gen_span + c.gap + 2 * MaxIdle;
  endtask

  // A size write also starts a new phase: the table is empty again.
  task automatic push_size(input logic [SizeW-1:0] sz);
    cmd_t c;
    c.kind = CmdSize;
    c.item = '0;
    c.size = sz;
    c.gap  = 0;
    stim_q = {stim_q, c};
    gen_span = span_of(sz);
    gen_keys.delete();
    budget += TableDepth + SettleCycles + 2 * MaxIdle + 10;
  endtask

  // Inserts mixed with lookups of keys already in, plus misses and
  // duplicate inserts. Long phases pause halfway until the block is empty.
  task automatic add_phase(input logic [SizeW-1:0] sz, input int unsigned count);
    cmd_t            c;
    int unsigned     r;
    logic [KeyW-1:0] k;
    push_size(sz);
    for (int unsigned i = 0; i < count; i++) begin
      gen_calm = ((i / 40) % 3 == 2);
      if (count >= 100 && i == count / 2) begin
        c.kind = CmdDrain;
        c.item = '0;
        c.size = '0;
        c.gap  = 0;
        stim_q = {stim_q, c};
        budget += SettleCycles + 2;
      end
      r = $urandom_range(0, 99);
      if (r < 45) begin
        if (r < 7 && gen_keys.size() != 0)
          k = gen_keys[$urandom_range(0, gen_keys.size() - 1)];
        else
          k = draw_key(gen_span);
        gen_keys = {gen_keys, k};
        push_item(KindInsert, k);
      end else if (r < 85 && gen_keys.size() != 0) begin
        push_item(KindQuery, gen_keys[$urandom_range(0, gen_keys.size() - 1)]);
      end else begin
        push_item(KindQuery, draw_key(gen_span));
      end
    end
    gen_calm = 1'b0;
  endtask

  task automatic flag_field(input string name, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      error_cnt++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // driver: offers items and size writes; predicts at the accepting edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : driver
    cmd_t head;
    bit   item_taken;
    bit   cfg_taken;
    bit   nxt_valid;
    bit   nxt_cfg;
    item_taken = in_valid_i && !in_stall_o;
    cfg_taken  = cfg_valid_i && cfg_ready_o;
    nxt_valid  = in_valid_i && !item_taken;
    nxt_cfg    = cfg_valid_i && !cfg_taken;
    if (rst_ni) begin
      if (item_taken) begin
        due_results = {due_results, walk_table(in_item_i)};
        n_issued <= n_issued + 1;
        if (in_item_i.kind == KindInsert) n_inserts <= n_inserts + 1;
        else n_queries <= n_queries + 1;
      end
      if (cfg_taken) begin
        // any size write empties the table
        mdl_size = cfg_data_i;
        foreach (mdl_used[i]) mdl_used[i] = 1'b0;
        n_size_writes <= n_size_writes + 1;
      end
      if (!nxt_valid && !nxt_cfg && stim_q.size() != 0) begin
        head = stim_q[0];
        if (head.kind == CmdItem) begin
          if (gap_cnt < head.gap) begin
            gap_cnt <= gap_cnt + 1;
          end else begin
            gap_cnt   <= 0;
            in_item_i <= head.item;
            nxt_valid = 1'b1;
            void'(stim_q.pop_front());
          end
        end else if (!item_taken && n_issued == n_retired) begin
          // everything out; let the block settle before touching it
          if (settle_cnt < SettleCycles) begin
            settle_cnt <= settle_cnt + 1;
          end else begin
            settle_cnt <= 0;
            if (head.kind == CmdSize) begin
              cfg_data_i <= head.size;
              nxt_cfg = 1'b1;
            end
            void'(stim_q.pop_front());
          end
        end else begin
          settle_cnt <= 0;
        end
      end
    end
    in_valid_i  <= nxt_valid;
    cfg_valid_i <= nxt_cfg;
  end

  // ---------------------------------------------------------------------------
  // monitor: checks each result against the oldest prediction; random stall
  // with a quiet window at the start of each repeating block of cycles
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : monitor
    out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (due_results.size() == 0) begin
          error_cnt++;
          $display("%0t: result with nothing pending, expected none, got %0d/%0d/%0d",
                   $time, out_item_o.status, out_item_o.slot_index,
                   out_item_o.probe_count);
        end else begin
          want = due_results.pop_front();
          n_retired <= n_retired + 1;
          status_hits[want.status]++;
          flag_field("status", 32'(want.status), 32'(out_item_o.status));
          flag_field("slot_index", 32'(want.slot_index), 32'(out_item_o.slot_index));
          flag_field("probe_count", 32'(want.probe_count),
                     32'(out_item_o.probe_count));
        end
      end
      if (hold_left != 0) begin
        hold_left   <= hold_left - 1;
        out_stall_i <= 1'b1;
      end else if ((cyc_cnt % 3000) < 600 || $urandom_range(0, 9) < 7) begin
        out_stall_i <= 1'b0;
      end else begin
        hold_left   <= draw_idle();
        out_stall_i <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin : watchdog
    cyc_cnt <= cyc_cnt + 1;
    if (cyc_cnt >= cycle_limit) begin
      $display("%0t: no progress after %0d cycles", $time, cyc_cnt);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus plan, reset, and end of run
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    // reset clears the table with a full-depth pass
    budget   = 2 * TableDepth + 1000;
    gen_span = span_of(SizeReset);

    // default size: key extremes, a miss one probe past home, a miss at home
    push_item(KindInsert, '0);
    push_item(KindInsert, '1);
    push_item(KindQuery, '1);
    push_item(KindQuery, 31'd1024);
    push_item(KindQuery, 31'd5);

    // four slots: step cycling over two slots hits the walk limit,
    // a zero step taken as one, a query that walks the whole full table
    push_size(11'd4);
    push_item(KindInsert, 31'd0);
    push_item(KindInsert, 31'd2);
    push_item(KindInsert, 31'd8);
    push_item(KindInsert, 31'd4);
    push_item(KindInsert, 31'd16);
    push_item(KindQuery, 31'd8);
    push_item(KindQuery, 31'd5);
    push_item(KindQuery, 31'd16);
    push_item(KindQuery, 31'd0);
    push_item(KindInsert, 31'd7);

    // size zero acts as one slot
    push_size('0);
    push_item(KindInsert, '1);
    push_item(KindInsert, 31'd3);
    push_item(KindQuery, '1);
    push_item(KindQuery, 31'd0);

    // oversize clamps to the full depth
    push_size('1);
    push_item(KindInsert, '1);
    push_item(KindQuery, 31'd5);

    // random phases over a spread of sizes, small ones filling up
    add_phase(11'd1024, 150);
    add_phase(11'd1, 60);
    add_phase(11'd2, 80);
    add_phase(11'd3, 80);
    add_phase(11'd4, 100);
    add_phase(11'd7, 100);
    add_phase(11'd8, 100);
    add_phase(11'd16, 150);
    add_phase(11'd31, 150);
    add_phase(11'd64, 200);
    add_phase(11'd0, 40);
    add_phase(11'd2047, 120);
    add_phase(11'd100, 150);
    add_phase(11'd1500, 80);
    add_phase(11'd255, 150);
    add_phase(11'd1023, 80);

    cycle_limit = 4 * budget;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (stim_q.size() != 0 || in_valid_i || cfg_valid_i || n_issued != n_retired)
      @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);

    $display("run covered %0d inserts and %0d queries across %0d table size writes",
             n_inserts, n_queries, n_size_writes);
    $display("outcomes: %0d home, %0d probed, %0d full, %0d found, %0d missing",
             status_hits[StHome], status_hits[StProbed], status_hits[StFull],
             status_hits[StFound], status_hits[StMissing]);
    if (due_results.size() != 0)
      $display("%0t: %0d predicted results never arrived", $time, due_results.size());
    if (error_cnt == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/lqh_pkg.sv
hdl/linear_quotient_hash_table_top.sv
sim/tb_linear_quotient_hash_table_top.sv
